// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define SMF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("smf assertion failed");
// cons must hold in the cycle after ante
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smf assertion failed");
`else
`define SMF_ASSERT(label, clk, rst_n, prop)
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types of the sliding window median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smf_pkg;

	// status one cell shows its neighbors
	typedef struct packed {
		logic gt;   // held value above the incoming sample
		logic ged;  // at or above the slot being retired
		logic del;  // holds the oldest sample
	} smf_flags_t;

endpackage

// ===== rtl/core/sliding_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Median of the last WINDOW samples, kept as a sorted chain of cells.
//
//   channel  signals                        moves
//   in       in_valid, in_ready, sample     one converter sample per transfer
//   out      out_valid, out_ready, median   one median per input transfer
//
// One sample per cycle unless stalled; the chain re-sorts in the cycle of the
// transfer and the median shows the next cycle from the middle cells.
// in_ready is high while the result register is empty or being drained.
// Reset clears every cell to zero with distinct ages; no clearing pass.
// A stalled output holds both the result and further input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_median_filter import smf_pkg::*; #(
	parameter int WINDOW      = 30,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] median
);

	localparam int AW = $clog2(WINDOW);

	logic [SAMPLE_BITS-1:0] val_w [WINDOW];
	logic [AW-1:0]          age_w [WINDOW];
	smf_flags_t             flags_w [WINDOW];
	logic [WINDOW-1:0]      del_w;
	logic [WINDOW-2:0]      sorted_ok;
	logic [SAMPLE_BITS-1:0] vd;
	logic                   load;
	logic                   out_valid_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// value of the retiring entry
	always_comb begin
		vd = '0;
		for (int i = 0; i < WINDOW; i++) begin
			vd = vd | (val_w[i] & {SAMPLE_BITS{del_w[i]}});
		end
	end

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lv;
		logic [AW-1:0]          la;
		smf_flags_t             lf;
		logic [SAMPLE_BITS-1:0] rv;
		logic [AW-1:0]          ra;
		smf_flags_t             rf;

		if (i == 0) begin : g_lo
			assign lv = '0;
			assign la = '0;
			assign lf = '0;
		end else begin : g_lo
			assign lv = val_w[i-1];
			assign la = age_w[i-1];
			assign lf = flags_w[i-1];
		end

		if (i == WINDOW - 1) begin : g_hi
			assign rv = '0;
			assign ra = '0;
			assign rf = '0;
		end else begin : g_hi
			assign rv = val_w[i+1];
			assign ra = age_w[i+1];
			assign rf = flags_w[i+1];
		end

		smf_cell #(
			.WINDOW      (WINDOW),
			.SAMPLE_BITS (SAMPLE_BITS),
			.IDX         (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (load),
			.x           (sample),
			.vd          (vd),
			.left_val    (lv),
			.left_age    (la),
			.left_flags  (lf),
			.right_val   (rv),
			.right_age   (ra),
			.right_flags (rf),
			.val         (val_w[i]),
			.age         (age_w[i]),
			.flags       (flags_w[i])
		);

		assign del_w[i] = flags_w[i].del;

		if (i < WINDOW - 1) begin : g_ord
			assign sorted_ok[i] = val_w[i] <= val_w[i+1];
		end
	end

	if ((WINDOW % 2) != 0) begin : g_odd
		assign median = val_w[(WINDOW - 1) / 2];
	end else begin : g_even
		logic [SAMPLE_BITS:0] sum;
		assign sum    = {1'b0, val_w[WINDOW/2]} + {1'b0, val_w[WINDOW/2 - 1]};
		assign median = sum[SAMPLE_BITS:1];
	end

	`SMF_ASSERT(a_one_oldest, clk, arst_n, $onehot(del_w))
	`SMF_ASSERT(a_sorted, clk, arst_n, &sorted_ok)
	`SMF_ASSERT_NEXT(a_result_after_load, clk, arst_n, load, out_valid)
	`SMF_ASSERT_NEXT(a_hold_chain, clk, arst_n, !load, $stable(val_w[0]) && $stable(age_w[0]))

endmodule

// ===== rtl/core/smf_cell.sv =====
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window: drops the oldest entry and inserts the new
// sample from its own value and those of its two neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smf_cell import smf_pkg::*; #(
	parameter int WINDOW      = 30,
	parameter int SAMPLE_BITS = 12,
	parameter int IDX         = 0,
	localparam int AW         = $clog2(WINDOW)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [SAMPLE_BITS-1:0] x,
	input  logic [SAMPLE_BITS-1:0] vd,
	input  logic [SAMPLE_BITS-1:0] left_val,
	input  logic [AW-1:0]          left_age,
	input  smf_flags_t             left_flags,
	input  logic [SAMPLE_BITS-1:0] right_val,
	input  logic [AW-1:0]          right_age,
	input  smf_flags_t             right_flags,
	output logic [SAMPLE_BITS-1:0] val,
	output logic [AW-1:0]          age,
	output smf_flags_t             flags
);

	localparam logic [AW-1:0] OLDEST    = AW'(WINDOW - 1);
	localparam logic [AW-1:0] AGE_RST   = AW'(WINDOW - 1 - IDX);
	localparam logic          FIRST     = (IDX == 0);
	localparam logic          LAST_CELL = (IDX == WINDOW - 1);

	logic [SAMPLE_BITS-1:0] val_q;
	logic [AW-1:0]          age_q;

	logic                   gt;
	logic                   ged;
	logic                   r_gt;
	logic                   p_gt;
	logic [SAMPLE_BITS-1:0] r_val;
	logic [SAMPLE_BITS-1:0] p_val;
	logic [AW-1:0]          r_age;
	logic [AW-1:0]          p_age;
	logic [SAMPLE_BITS-1:0] nxt_val;
	logic [AW-1:0]          nxt_age;

	always_comb begin
		gt  = val_q > x;
		// oldest entry is first among equals, so this marks it and all above
		ged = vd <= val_q;

		// this slot after removal
		r_gt  = ged ? (LAST_CELL | right_flags.gt) : gt;
		r_val = ged ? right_val : val_q;
		r_age = ged ? right_age : age_q;

		// slot below after removal
		p_gt  = FIRST ? 1'b0 : (left_flags.ged ? gt : left_flags.gt);
		p_val = left_flags.ged ? val_q : left_val;
		p_age = left_flags.ged ? age_q : left_age;

		if (!r_gt) begin
			nxt_val = r_val;
			nxt_age = r_age + AW'(1);
		end else if (p_gt) begin
			nxt_val = p_val;
			nxt_age = p_age + AW'(1);
		end else begin
			nxt_val = x;
			nxt_age = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			age_q <= AGE_RST;
		end else if (load) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

	assign val       = val_q;
	assign age       = age_q;
	assign flags.gt  = gt;
	assign flags.ged = ged;
	assign flags.del = (age_q == OLDEST);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window median filter.
//
// The bench keeps its own copy of the 30-entry sample window and computes the
// median after every accepted sample. The expected medians wait in a queue,
// and each median transfer on the output is checked against the oldest one.
// The run opens with a short table of directed samples: the window filling
// from its cleared state, the even-window average, and the field extremes.
// Random samples follow, mixing full-range values, extremes, tight clusters
// and repeated runs. Both sides idle at random in some phases and not in
// others. The receiver also holds off once for a long stretch so that the
// filter fills up and stalls its input.
// ----------------------------------------------------------------------------

module tb;

	localparam int WIN        = 30;
	localparam int BITS       = 12;
	localparam int NONE       = -1;
	localparam int N_DIR      = 21;
	localparam int N_RAND     = 900;
	localparam int CHUNK      = 100;
	localparam int HOLD_AT    = 400;
	localparam int HOLD_LEN   = 80;
	localparam int TAIL       = 20;
	localparam int MAX_SAMPLE = (1 << BITS) - 1;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [BITS-1:0] sample;
	logic            out_valid;
	logic            out_ready;
	logic [BITS-1:0] median;

	// bench copy of the filter state
	logic [BITS-1:0] win_buf [WIN];
	int              wr_pos;
	logic [BITS-1:0] median_q [$];

	int              errors;
	int              n_out;
	bit              tx_idle;
	bit              rx_idle;
	bit              hold_done;
	logic [BITS-1:0] cluster_base;
	logic [BITS-1:0] last_sample;
	logic [BITS-1:0] got_median;

	// directed samples; a typed median is checked as given, NONE uses the predictor
	logic [BITS-1:0] dir_sample [N_DIR] = '{
		12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
		12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
		12'd4095, 12'd4095, 12'd0, 12'd1, 12'd2730, 12'd1365, 12'd2048
	};
	int dir_median [N_DIR] = '{
		0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0,
		2047, 4095, NONE, NONE, NONE, NONE, NONE
	};

	sliding_window_median_filter #(
		.WINDOW     (WIN),
		.SAMPLE_BITS(BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median   (median)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [BITS-1:0] window_median();
		logic [BITS-1:0] srt [WIN];
		logic [BITS-1:0] v;
		logic [BITS:0]   sum;
		int              k;
		for (int n = 0; n < WIN; n++) begin
			v = win_buf[n];
			k = n;
			while (k > 0 && srt[k-1] > v) begin
				srt[k] = srt[k-1];
				k--;
			end
			srt[k] = v;
		end
		if (WIN % 2 != 0)
			return srt[(WIN-1)/2];
		sum = {1'b0, srt[WIN/2]} + {1'b0, srt[WIN/2-1]};
		return sum[BITS:1];
	endfunction

	// write the accepted sample into the window and queue the median it yields
	task automatic record_sample(input logic [BITS-1:0] s, input int typed);
		logic [BITS-1:0] m;
		win_buf[wr_pos] = s;
		wr_pos = (wr_pos == WIN-1) ? 0 : wr_pos + 1;
		m = window_median();
		if (typed == NONE)
			median_q.push_back(m);
		else
			median_q.push_back(typed[BITS-1:0]);
	endtask

	// entered and left at a falling edge
	task automatic send(input logic [BITS-1:0] s, input int typed);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		record_sample(s, typed);
		@(negedge clk);
	endtask

	function automatic logic [BITS-1:0] pick_sample();
		logic [BITS-1:0] s;
		case ($urandom_range(0, 9))
			0: s = '0;
			1: s = MAX_SAMPLE[BITS-1:0];
			2, 3: begin
				if ($urandom_range(0, 15) == 0)
					cluster_base = BITS'($urandom_range(0, MAX_SAMPLE));
				s = cluster_base ^ BITS'($urandom_range(0, 7));
			end
			4: s = last_sample;
			default: s = BITS'($urandom_range(0, MAX_SAMPLE));
		endcase
		last_sample = s;
		return s;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_out <= n_out + 1;
			if (median_q.size() == 0) begin
				$display("%0t: median transfer with none expected: got %0d",
					$time, median);
				errors++;
			end else begin
				got_median = median_q.pop_front();
				if (median !== got_median) begin
					$display("%0t: median mismatch: expected %0d, got %0d",
						$time, got_median, median);
					errors++;
				end
			end
		end
	end

	// receiver
	initial begin
		int w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = rx_idle ? $urandom_range(0, 7) : 0;
			if (!hold_done && n_out >= HOLD_AT) begin
				hold_done = 1'b1;
				w = HOLD_LEN;
			end
			@(negedge clk);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample       = '0;
		errors       = 0;
		n_out        = 0;
		tx_idle      = 1'b0;
		rx_idle      = 1'b0;
		hold_done    = 1'b0;
		cluster_base = '0;
		last_sample  = '0;
		wr_pos       = 0;
		for (int i = 0; i < WIN; i++)
			win_buf[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send(dir_sample[i], dir_median[i]);

		for (int i = 0; i < N_RAND; i++) begin
			if (i % CHUNK == 0) begin
				if (i / CHUNK < 4)
					{tx_idle, rx_idle} = 2'(i / CHUNK);
				else
					{tx_idle, rx_idle} = 2'($urandom_range(0, 3));
			end
			send(pick_sample(), NONE);
		end
		in_valid <= 1'b0;

		while (median_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
